@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ekbc_pkg.sv @@
`default_nettype none
package ekbc_pkg;

  typedef enum logic [1:0] {
    CMD_POLL       = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_SET_ON     = 2'd2,
    CMD_SET_BRIGHT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_TICKS     = 2'd0,
    REG_KNOB_STEP          = 2'd1,
    REG_DEFAULT_BRIGHTNESS = 2'd2
  } reg_idx_t;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic signed [7:0] PULSE_LIMIT      = 8'sd127;
  localparam logic        [7:0] LEVEL_MAX        = 8'd255;
  localparam logic        [7:0] BRIGHTNESS_RESET = 8'd128;
  localparam logic        [3:0] DEBOUNCE_RESET   = 4'd3;
  localparam logic        [5:0] STEP_RESET       = 6'd5;
  localparam logic        [7:0] DEFAULT_RESET    = 8'd128;

  typedef struct packed {
    logic [1:0] command;
    logic       enc_a;
    logic       enc_b;
    logic       button_level;
    logic [7:0] set_value;
  } in_t;

  typedef struct packed {
    logic       light_on;
    logic [7:0] brightness_level;
    logic [7:0] drive_level;
    logic       refresh;
  } out_t;

endpackage
`default_nettype wire

@@ sv/encoder_knob_brightness_control.sv @@
`default_nettype none
// Rotary-knob light controller. Each accepted input item gives exactly one result, held in
// the output register; a new item is accepted in the same cycle as a waiting result is taken,
// so the sustained rate is one item per cycle while out_stall is low, set by the single
// update of the state registers. Command 0 polls the encoder phases and
// accumulates a pulse count saturating at +/-127; command 1 is a slow tick that debounces
// the button (a press toggles the light, switching on loads the default brightness) and
// then applies half the pending pulses times the step to the brightness, clamped to 0..255;
// commands 2 and 3 set the on flag and the brightness. Registers at byte addresses 0, 4
// and 8: debounce ticks, brightness step, default brightness.
`include "assert_macros.svh"
module encoder_knob_brightness_control (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire ekbc_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output ekbc_pkg::out_t                    out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ekbc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ekbc_pkg::DATA_W-1:0]  pwdata,
  output logic      [ekbc_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import ekbc_pkg::*;

  // configuration registers
  logic [3:0] dbt_r;
  logic [5:0] step_r;
  logic [7:0] dflt_r;

  // block state
  logic              prev_a_r, prev_a_nxt;
  logic signed [7:0] pend_r, pend_nxt;
  logic              btn_acc_r, btn_acc_nxt;
  logic [3:0]        dbc_r, dbc_nxt;
  logic              on_r, on_nxt;
  logic [7:0]        bright_r, bright_nxt;

  logic out_valid_r;
  out_t out_data_r;
  out_t result;
  logic refresh;
  logic in_acc;
  logic cfg_wr;
  reg_idx_t cfg_idx;
  logic tick_acc, set_on_acc, off_shown;

  // tick datapath
  logic              pressed, btn_change, btn_fire, press_toggle, on_mid;
  logic [3:0]        dbc_inc;
  logic [7:0]        bright_mid, bright_knob;
  logic signed [7:0] pend_adj;
  logic signed [6:0] steps;
  logic signed [13:0] prod, sum;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbt_r  <= DEBOUNCE_RESET;
      step_r <= STEP_RESET;
      dflt_r <= DEFAULT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE_TICKS:     dbt_r  <= pwdata[3:0];
        REG_KNOB_STEP:          step_r <= pwdata[5:0];
        REG_DEFAULT_BRIGHTNESS: dflt_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE_TICKS:     prdata = {{(DATA_W-4){1'b0}}, dbt_r};
      REG_KNOB_STEP:          prdata = {{(DATA_W-6){1'b0}}, step_r};
      REG_DEFAULT_BRIGHTNESS: prdata = {{(DATA_W-8){1'b0}}, dflt_r};
      default:                prdata = '0;
    endcase
  end

  // output register frees up when its transfer completes
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // button debounce
  assign pressed      = ~in_data.button_level;
  assign btn_change   = (pressed != btn_acc_r);
  assign dbc_inc      = dbc_r + 4'd1;
  assign btn_fire     = btn_change && (dbc_inc >= dbt_r);
  assign press_toggle = btn_fire && pressed;
  assign on_mid       = on_r ^ press_toggle;
  assign bright_mid   = (press_toggle && !on_r) ? dflt_r : bright_r;

  // halve toward zero, then scale by the step
  assign pend_adj = pend_r + $signed({7'b0, pend_r[7]});
  assign steps    = pend_adj[7:1];
  assign prod     = 14'(steps) * 14'($signed({1'b0, step_r}));
  assign sum      = $signed({6'b0, bright_mid}) + prod;

  always_comb begin
    if (sum[13]) begin
      bright_knob = 8'd0;
    end else if (sum[12:8] != 5'd0) begin
      bright_knob = LEVEL_MAX;
    end else begin
      bright_knob = sum[7:0];
    end
  end

  always_comb begin
    prev_a_nxt  = prev_a_r;
    pend_nxt    = pend_r;
    btn_acc_nxt = btn_acc_r;
    dbc_nxt     = dbc_r;
    on_nxt      = on_r;
    bright_nxt  = bright_r;
    refresh     = 1'b0;
    case (cmd_t'(in_data.command))
      CMD_POLL: begin
        if (in_data.enc_a != prev_a_r) begin
          if (in_data.enc_b != prev_a_r) begin
            if (pend_r < PULSE_LIMIT) pend_nxt = pend_r + 8'sd1;
          end else begin
            if (pend_r > -PULSE_LIMIT) pend_nxt = pend_r - 8'sd1;
          end
        end
        prev_a_nxt = in_data.enc_a;
      end
      CMD_TICK: begin
        if (!btn_change || btn_fire) begin
          dbc_nxt = 4'd0;
        end else begin
          dbc_nxt = dbc_inc;
        end
        if (btn_fire) btn_acc_nxt = pressed;
        on_nxt   = on_mid;
        pend_nxt = 8'sd0;
        if (steps != 7'sd0) begin
          bright_nxt = bright_knob;
          refresh    = press_toggle || on_mid;
        end else begin
          bright_nxt = bright_mid;
          refresh    = press_toggle;
        end
      end
      CMD_SET_ON: begin
        on_nxt = (in_data.set_value != 8'd0);
        if ((in_data.set_value != 8'd0) && (bright_r == 8'd0)) bright_nxt = dflt_r;
        refresh = 1'b1;
      end
      CMD_SET_BRIGHT: begin
        bright_nxt = in_data.set_value;
        refresh    = on_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.light_on         = on_nxt;
    result.brightness_level = bright_nxt;
    result.drive_level      = on_nxt ? bright_nxt : 8'd0;
    result.refresh          = refresh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r    <= 1'b1;
      pend_r      <= 8'sd0;
      btn_acc_r   <= 1'b0;
      dbc_r       <= 4'd0;
      on_r        <= 1'b0;
      bright_r    <= BRIGHTNESS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_a_r    <= prev_a_nxt;
        pend_r      <= pend_nxt;
        btn_acc_r   <= btn_acc_nxt;
        dbc_r       <= dbc_nxt;
        on_r        <= on_nxt;
        bright_r    <= bright_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= result;
  end

  assign tick_acc   = in_acc && (in_data.command == CMD_TICK);
  assign set_on_acc = in_acc && (in_data.command == CMD_SET_ON) && (in_data.set_value != 8'd0);
  assign off_shown  = out_valid_r && !out_data_r.light_on;

  `ASSERT_SAME(a_pend_sat, clk, rst_n, 1'b1, pend_r != 8'sh80, "pulse count left its range")
  `ASSERT_NEXT(a_tick_clears, clk, rst_n, tick_acc, pend_r == 8'sd0, "tick left pulses")
  `ASSERT_SAME(a_drive_off, clk, rst_n, off_shown, out_data_r.drive_level == '0, "drive while off")
  `ASSERT_NEXT(a_set_on, clk, rst_n, set_on_acc, on_r && out_data_r.refresh, "set-on not applied")

endmodule
`default_nettype wire

@@ sim/tb_encoder_knob_brightness_control.sv @@
module tb_encoder_knob_brightness_control;
  import ekbc_pkg::*;

  class light_state_board;
    logic [3:0] debounce_ticks;
    logic [5:0] knob_step;
    logic [7:0] default_brightness;
    logic prev_a;
    logic signed [7:0] pulses;
    logic pressed_state;
    logic [3:0] bounce_count;
    logic light;
    logic [7:0] level;
    out_t results_due[$];
    int errors;
    int sat_hits;

    function new();
      debounce_ticks = DEBOUNCE_RESET;
      knob_step = STEP_RESET;
      default_brightness = DEFAULT_RESET;
      prev_a = 1'b1;
      pulses = '0;
      pressed_state = 1'b0;
      bounce_count = '0;
      light = 1'b0;
      level = BRIGHTNESS_RESET;
      errors = 0;
      sat_hits = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_DEBOUNCE_TICKS:     debounce_ticks = value[3:0];
        REG_KNOB_STEP:          knob_step = value[5:0];
        REG_DEFAULT_BRIGHTNESS: default_brightness = value[7:0];
        default: ;
      endcase
    endfunction

    function void accept_command(in_t item);
      out_t res;
      logic pressed;
      logic signed [7:0] steps;
      int sum;
      logic refresh;
      refresh = 1'b0;
      case (cmd_t'(item.command))
        CMD_POLL: begin
          if (item.enc_a != prev_a) begin
            if (item.enc_b != prev_a) begin
              if (pulses < 8'sd127) pulses++;
              else sat_hits++;
            end else begin
              if (pulses > -8'sd127) pulses--;
              else sat_hits++;
            end
          end
          prev_a = item.enc_a;
        end
        CMD_TICK: begin
          pressed = ~item.button_level;
          if (pressed == pressed_state) begin
            bounce_count = '0;
          end else begin
            bounce_count = bounce_count + 4'd1;
            if (bounce_count >= debounce_ticks) begin
              pressed_state = pressed;
              bounce_count = '0;
              if (pressed) begin
                light = ~light;
                if (light) level = default_brightness;
                refresh = 1'b1;
              end
            end
          end
          // two pulses per detent, an odd one is dropped
          steps = pulses / 8'sd2;
          pulses = '0;
          if (steps != 0) begin
            sum = int'(level) + int'(steps) * int'(knob_step);
            if (sum < 0) sum = 0;
            if (sum > 255) sum = 255;
            level = sum[7:0];
            if (light) refresh = 1'b1;
          end
        end
        CMD_SET_ON: begin
          light = (item.set_value != 8'd0);
          if (light && level == 8'd0) level = default_brightness;
          refresh = 1'b1;
        end
        CMD_SET_BRIGHT: begin
          level = item.set_value;
          refresh = light;
        end
        default: ;
      endcase
      res.light_on = light;
      res.brightness_level = level;
      res.drive_level = light ? level : 8'd0;
      res.refresh = refresh;
      results_due.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected: %p", got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.light_on !== want.light_on) begin
        $error("light_on: expected %0d, got %0d", want.light_on, got.light_on);
        errors++;
      end
      if (got.brightness_level !== want.brightness_level) begin
        $error("brightness_level: expected %0d, got %0d",
               want.brightness_level, got.brightness_level);
        errors++;
      end
      if (got.drive_level !== want.drive_level) begin
        $error("drive_level: expected %0d, got %0d", want.drive_level, got.drive_level);
        errors++;
      end
      if (got.refresh !== want.refresh) begin
        $error("refresh: expected %0d, got %0d", want.refresh, got.refresh);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  light_state_board board = new();
  int idle_cap = 0;
  int items_sent = 0;
  int reg_writes = 0;
  int refresh_seen = 0;

  encoder_knob_brightness_control dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int draw_wait();
    return (idle_cap == 0) ? 0 : $urandom_range(0, idle_cap);
  endfunction

  // result side: random stall before each transfer
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= (hold != 0);
      if (hold != 0) hold--;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (out_data.refresh) refresh_seen++;
        board.check_result(out_data);
        hold = draw_wait();
      end
    end
  end

  task automatic send_item(in_t item);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    board.accept_command(item);
    items_sent++;
  endtask

  task automatic poll(logic a, logic b);
    in_t item;
    item.command = CMD_POLL;
    item.enc_a = a;
    item.enc_b = b;
    item.button_level = 1'($urandom_range(0, 1));
    item.set_value = 8'($urandom_range(0, 255));
    send_item(item);
  endtask

  task automatic tick(logic btn);
    in_t item;
    item.command = CMD_TICK;
    item.enc_a = 1'($urandom_range(0, 1));
    item.enc_b = 1'($urandom_range(0, 1));
    item.button_level = btn;
    item.set_value = 8'($urandom_range(0, 255));
    send_item(item);
  endtask

  task automatic setting(cmd_t c, logic [7:0] v);
    in_t item;
    item.command = c;
    item.enc_a = 1'($urandom_range(0, 1));
    item.enc_b = 1'($urandom_range(0, 1));
    item.button_level = 1'($urandom_range(0, 1));
    item.set_value = v;
    send_item(item);
  endtask

  // one detent direction per call, with the odd contact bounce
  task automatic spin(int len, bit up);
    logic pa;
    repeat (len) begin
      pa = board.prev_a;
      if ($urandom_range(0, 7) == 0) poll(pa, 1'($urandom_range(0, 1)));
      else poll(~pa, up ? ~pa : pa);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.results_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (board.results_due.size() != 0) begin
      $error("%0d expected results never arrived", board.results_due.size());
      board.errors++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int quota);
    int start;
    int need;
    int n;
    logic lvl;
    start = items_sent;
    while (items_sent - start < quota) begin
      case ($urandom_range(0, 3))
        0: idle_cap = 0;
        1: idle_cap = 19;
        default: idle_cap = 3;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
          spin(n, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 3) != 0) tick(~board.pressed_state);
          else tick(1'($urandom_range(0, 1)));
        end
        4, 5: begin
          // a press or a release, sometimes cut short like a glitch
          lvl = board.pressed_state;
          need = (board.debounce_ticks == 0) ? 1 : int'(board.debounce_ticks);
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, need)
                                           : need + $urandom_range(0, 2);
          repeat (n) tick(lvl);
        end
        6: setting(CMD_SET_ON, ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        7: setting(CMD_SET_BRIGHT, 8'($urandom_range(0, 255)));
        default: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0: poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
              1: tick(1'($urandom_range(0, 1)));
              2: setting(CMD_SET_ON, 8'($urandom_range(0, 255)));
              default: setting(CMD_SET_BRIGHT, 8'($urandom_range(0, 255)));
            endcase
          end
        end
      endcase
    end
  endtask

  initial begin
    logic [3:0] ticks_val;
    logic [5:0] step_val;
    logic [7:0] dflt_val;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset register values
    idle_cap = 5;
    setting(CMD_SET_ON, 8'd0);
    setting(CMD_SET_BRIGHT, 8'd0);
    setting(CMD_SET_ON, 8'hff);       // switch on at zero brightness loads the default
    setting(CMD_SET_BRIGHT, 8'hff);
    poll(1'b0, 1'b0);
    poll(1'b1, 1'b1);
    poll(1'b0, 1'b0);
    poll(1'b1, 1'b1);
    tick(1'b1);                       // clamps at the top
    setting(CMD_SET_BRIGHT, 8'd3);
    poll(1'b0, 1'b1);
    poll(1'b1, 1'b0);
    poll(1'b0, 1'b1);
    poll(1'b1, 1'b0);
    tick(1'b1);                       // clamps at zero
    poll(1'b0, 1'b0);
    poll(1'b1, 1'b1);
    poll(1'b0, 1'b0);
    poll(1'b0, 1'b1);                 // phase a unchanged, no count
    tick(1'b1);                       // odd pulse lost
    repeat (3) tick(1'b0);            // press taken, light toggles off
    repeat (3) tick(1'b1);            // release taken quietly
    setting(CMD_SET_ON, 8'h01);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin ticks_val = 4'd1;  step_val = 6'd63; dflt_val = 8'd0;   end
        1: begin ticks_val = 4'd15; step_val = 6'd1;  dflt_val = 8'd255; end
        // zero debounce ticks and a zero step
        2: begin ticks_val = 4'd0;  step_val = 6'd0;  dflt_val = 8'd128; end
        default: begin
          ticks_val = 4'($urandom_range(1, 15));
          step_val = 6'($urandom_range(1, 63));
          dflt_val = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(REG_DEBOUNCE_TICKS, 32'(ticks_val));
      write_reg(REG_KNOB_STEP, 32'(step_val));
      write_reg(REG_DEFAULT_BRIGHTNESS, 32'(dflt_val));
      run_phase(240);
      drain();
    end

    $display("run covered %0d commands over %0d register writes", items_sent, reg_writes);
    $display("%0d results asked for a strip refresh, pulse count saturated %0d times",
             refresh_seen, board.sat_hits);
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/ekbc_pkg.sv
sv/encoder_knob_brightness_control.sv
sim/tb_encoder_knob_brightness_control.sv
